// ===== hw/rtl/oiwf_pkg.sv =====
// package for the oled i2c write framer
// word types, bus symbol codes and framing constants; no dependencies
`timescale 1ns / 1ps

package oiwf_pkg;

    localparam logic [7:0] ADDR_RESET   = 8'h78;
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] BYTE_MSB     = 8'h80;

    localparam logic       OP_COMMAND = 1'b0;
    localparam logic       OP_DATA    = 1'b1;

    localparam logic [1:0] SYM_START = 2'd0;
    localparam logic [1:0] SYM_BIT   = 2'd1;
    localparam logic [1:0] SYM_ACK   = 2'd2;
    localparam logic [1:0] SYM_STOP  = 2'd3;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned FRAME_BYTES   = 3;
    localparam int unsigned FRAME_BITS    = BITS_PER_BYTE * FRAME_BYTES;

    typedef struct packed {
        logic       opcode;
        logic [7:0] payload;
    } t_in_word;

    typedef struct packed {
        logic [1:0] symbol;
        logic       sda_level;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] payload;
    } t_job;

endpackage

// ===== hw/rtl/oiwf_front.sv =====
// front end: accepts request words, picks the control byte, queues frame jobs
// depends on oiwf_pkg
`timescale 1ns / 1ps

module oiwf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  oiwf_pkg::t_in_word i_in_word,
    input  logic [7:0]        i_addr,
    output logic              o_job_valid,
    output oiwf_pkg::t_job    o_job,
    input  logic              i_pop
);

    oiwf_pkg::t_job r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    logic           w_push;
    logic           w_pop;
    oiwf_pkg::t_job w_job;

    always_comb begin
        w_job.addr    = i_addr;
        w_job.payload = i_in_word.payload;
        unique case (i_in_word.opcode)
            oiwf_pkg::OP_DATA:    w_job.ctrl = oiwf_pkg::CTRL_DATA;
            oiwf_pkg::OP_COMMAND: w_job.ctrl = oiwf_pkg::CTRL_COMMAND;
            default:              w_job.ctrl = oiwf_pkg::CTRL_COMMAND;
        endcase
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_pop && (r_count != 2'd0);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_job;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !w_pop) |=> (r_count == 2'd2))
        else $error("full queue lost an entry");

endmodule

// ===== hw/rtl/oiwf_back.sv =====
// back end: serializes one frame job into start, 27 bit/ack symbols and stop
// depends on oiwf_pkg
`timescale 1ns / 1ps

module oiwf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  oiwf_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output oiwf_pkg::t_out_word o_out_word
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_BITS  = 2'd2;
    localparam logic [1:0] ST_STOP  = 2'd3;

    localparam logic [3:0] ACK_SLOT = 4'(oiwf_pkg::BITS_PER_BYTE);
    localparam logic [1:0] LAST_BYTE = 2'(oiwf_pkg::FRAME_BYTES - 1);

    logic [1:0]                      r_state, n_state;
    logic [oiwf_pkg::FRAME_BITS-1:0] r_shift, n_shift;
    logic [3:0]                      r_bit, n_bit;
    logic [1:0]                      r_byte, n_byte;
    logic                            r_out_valid, n_out_valid;
    oiwf_pkg::t_out_word             r_out, n_out;
    logic                            w_advance;

    assign w_advance   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state     = r_state;
        n_shift     = r_shift;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (w_advance) begin
            n_out_valid = 1'b1;
            unique case (r_state)
                ST_IDLE: begin
                    n_out = '{symbol: oiwf_pkg::SYM_START, sda_level: 1'b0, last: 1'b0};
                    if (i_job_valid) begin
                        o_pop   = 1'b1;
                        n_shift = i_job;
                        n_bit   = 4'd0;
                        n_byte  = 2'd0;
                        n_state = ST_BITS;
                    end else begin
                        n_out_valid = 1'b0;
                    end
                end
                ST_START: begin
                    n_out   = '{symbol: oiwf_pkg::SYM_START, sda_level: 1'b0, last: 1'b0};
                    n_bit   = 4'd0;
                    n_byte  = 2'd0;
                    n_state = ST_BITS;
                end
                ST_BITS: begin
                    if (r_bit == ACK_SLOT) begin
                        n_out = '{symbol: oiwf_pkg::SYM_ACK, sda_level: 1'b1, last: 1'b0};
                        n_bit = 4'd0;
                        if (r_byte == LAST_BYTE) begin
                            n_state = ST_STOP;
                        end else begin
                            n_byte = r_byte + 2'd1;
                        end
                    end else begin
                        n_out = '{symbol: oiwf_pkg::SYM_BIT,
                                  sda_level: r_shift[oiwf_pkg::FRAME_BITS-1],
                                  last: 1'b0};
                        n_shift = {r_shift[oiwf_pkg::FRAME_BITS-2:0], 1'b0};
                        n_bit   = r_bit + 4'd1;
                    end
                end
                ST_STOP: begin
                    n_out = '{symbol: oiwf_pkg::SYM_STOP, sda_level: 1'b1, last: 1'b1};
                    if (i_job_valid) begin
                        o_pop   = 1'b1;
                        n_shift = i_job;
                        n_state = ST_START;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                default: begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bit       <= 4'd0;
            r_byte      <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bit       <= n_bit;
            r_byte      <= n_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_out   <= n_out;
    end

    a_last_only_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.symbol == oiwf_pkg::SYM_STOP))
        else $error("last flag on a symbol other than stop");

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_job_valid)
        else $error("pop from empty queue");

    a_counters_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit <= ACK_SLOT) && (r_byte <= LAST_BYTE))
        else $error("bit or byte counter out of range");

    a_start_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START) |-> (r_out_valid && r_out.symbol == oiwf_pkg::SYM_STOP))
        else $error("pending start not preceded by stop");

endmodule

// ===== hw/rtl/oled_i2c_write_framer_core.sv =====
// top level of the oled i2c write framer: slave address register, front queue, back serializer
// depends on oiwf_pkg, oiwf_front, oiwf_back
//
//   channel | valid       | stall        | word
//   in      | i_in_valid  | o_in_stall   | i_in_word  (opcode, payload)
//   out     | o_out_valid | i_out_stall  | o_out_word (symbol, sda_level, last)
//   config  | i_cfg_we    | -            | i_cfg_wdata (slave address byte)
//
// each request gives 29 output words, one per cycle from the serializer output register while i_out_stall is low
// the serializer emits one symbol per cycle unless stalled, and pops the next job as it emits a stop
// a taken request is first written into the job queue; its first word then comes from the output register
// a two-entry job queue lets requests be taken while the serializer is busy or stalled
// synchronous active-low reset empties the queue and sets the slave address to 0x78
`timescale 1ns / 1ps

module oled_i2c_write_framer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  oiwf_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output oiwf_pkg::t_out_word o_out_word
);

    logic [7:0]     r_slave_addr;
    logic           w_job_valid;
    oiwf_pkg::t_job w_job;
    logic           w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= oiwf_pkg::ADDR_RESET;
        end else if (i_cfg_we) begin
            r_slave_addr <= i_cfg_wdata;
        end
    end

    oiwf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_addr      (r_slave_addr),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_pop       (w_pop)
    );

    oiwf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
